// ===== sv/best_fit_partition_allocator_assert.svh =====
// assertion macros for the best-fit partition allocator
// used by best_fit_partition_allocator.sv, expects clk and rst_n in scope
`ifndef BEST_FIT_PARTITION_ALLOCATOR_ASSERT_SVH
`define BEST_FIT_PARTITION_ALLOCATOR_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define BFPA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define BFPA_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define BFPA_ASSERT(lbl, prop, msg)
`define BFPA_ASSERT_RST(lbl, prop, msg)
`endif
`endif

// ===== sv/bfpa_pkg.sv =====
// shared constants and operation codes for the best-fit partition allocator
// no dependencies
package bfpa_pkg;

  localparam int MAX_PARTS = 16;
  localparam int SIZE_W    = 16;
  localparam int SLOT_W    = 4;
  localparam int CFG_W     = 5;
  localparam int CNT_W     = $clog2(MAX_PARTS + 1);
  localparam int FUNC_W    = 2;

  localparam logic [FUNC_W-1:0] FUNC_LOAD  = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_ALLOC = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_CLEAR = 2'd2;

  typedef logic [SIZE_W-1:0] size_t;
  typedef logic [SLOT_W-1:0] slot_t;
  typedef logic [CNT_W-1:0]  cnt_t;

endpackage

// ===== sv/best_fit_partition_allocator.sv =====
// Best-fit fixed-partition allocator. Load and clear requests, and the unused
// operation code, give their single all-zero result in the cycle after they are
// taken. An allocate request walks the size table one entry per cycle through
// a single compare unit, over the first min(partitions_in_use, 16) entries;
// the block takes no new request until its result has gone into the output
// register. Ties go to the lowest index.
// depends on bfpa_pkg.sv and best_fit_partition_allocator_assert.svh
module best_fit_partition_allocator (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [bfpa_pkg::CFG_W-1:0]  cfg_data,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [bfpa_pkg::FUNC_W-1:0] in_func,
  input  logic [bfpa_pkg::SLOT_W-1:0] in_slot,
  input  logic [bfpa_pkg::SIZE_W-1:0] in_amount,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic                        out_granted,
  output logic [bfpa_pkg::SLOT_W-1:0] out_chosen_slot,
  output logic [bfpa_pkg::SIZE_W-1:0] out_chosen_size
);
  import bfpa_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_DONE = 2'd2;

  localparam cnt_t MAX_CNT = CNT_W'(MAX_PARTS);

  logic [1:0]           state_r, state_nxt;
  logic [CFG_W-1:0]     piu_r;
  size_t                size_mem [MAX_PARTS];
  size_t                rd_size_r;
  logic [MAX_PARTS-1:0] occ_r;
  size_t                req_r, req_nxt;
  cnt_t                 cnt_r, cnt_nxt;
  cnt_t                 idx_r, idx_nxt;
  logic                 found_r, found_nxt;
  slot_t                best_r, best_nxt;
  size_t                best_size_r, best_size_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic                 out_granted_r, out_granted_nxt;
  slot_t                out_slot_r, out_slot_nxt;
  size_t                out_size_r, out_size_nxt;

  logic  out_free;
  logic  in_take;
  slot_t scan_slot;
  slot_t cmp_slot;
  logic  scan_hit;
  cnt_t  cnt_clamped;

  assign cfg_ready = 1'b1;
  assign out_free  = !out_valid_r || out_ready;
  assign in_ready  = (state_r == ST_IDLE) && out_free;
  assign in_take   = in_valid && in_ready;

  assign out_valid       = out_valid_r;
  assign out_granted     = out_granted_r;
  assign out_chosen_slot = out_slot_r;
  assign out_chosen_size = out_size_r;

  assign cnt_clamped = (piu_r > CFG_W'(MAX_PARTS)) ? MAX_CNT : CNT_W'(piu_r);

  // shared compare unit: one table entry per cycle
  // table read is registered, so the compare runs one entry behind the read address
  assign scan_slot = idx_r[SLOT_W-1:0];
  assign cmp_slot  = scan_slot - 1'b1;
  assign scan_hit  = (idx_r != '0) && !occ_r[cmp_slot] && (rd_size_r >= req_r) &&
                     (!found_r || (rd_size_r < best_size_r));

  always_comb begin
    state_nxt       = state_r;
    req_nxt         = req_r;
    cnt_nxt         = cnt_r;
    idx_nxt         = idx_r;
    found_nxt       = found_r;
    best_nxt        = best_r;
    best_size_nxt   = best_size_r;
    out_valid_nxt   = out_valid_r && !out_ready;
    out_granted_nxt = out_granted_r;
    out_slot_nxt    = out_slot_r;
    out_size_nxt    = out_size_r;
    case (state_r)
      ST_IDLE: begin
        if (in_take) begin
          if (in_func == FUNC_ALLOC) begin
            req_nxt   = in_amount;
            cnt_nxt   = cnt_clamped;
            idx_nxt   = '0;
            found_nxt = 1'b0;
            state_nxt = ST_SCAN;
          end else begin
            out_valid_nxt   = 1'b1;
            out_granted_nxt = 1'b0;
            out_slot_nxt    = '0;
            out_size_nxt    = '0;
          end
        end
      end
      ST_SCAN: begin
        if (scan_hit) begin
          found_nxt     = 1'b1;
          best_nxt      = cmp_slot;
          best_size_nxt = rd_size_r;
        end
        if (idx_r == cnt_r) begin
          state_nxt = ST_DONE;
        end else begin
          idx_nxt = idx_r + 1'b1;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          out_valid_nxt   = 1'b1;
          out_granted_nxt = found_r;
          out_slot_nxt    = found_r ? best_r : '0;
          out_size_nxt    = found_r ? best_size_r : '0;
          state_nxt       = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      piu_r       <= '0;
      occ_r       <= '0;
      out_valid_r <= 1'b0;
      found_r     <= 1'b0;
      idx_r       <= '0;
      cnt_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      found_r     <= found_nxt;
      idx_r       <= idx_nxt;
      cnt_r       <= cnt_nxt;
      if (cfg_valid && cfg_ready) begin
        piu_r <= cfg_data;
      end
      if (in_take && in_func == FUNC_LOAD) begin
        occ_r[in_slot] <= 1'b0;
      end else if (in_take && in_func == FUNC_CLEAR) begin
        occ_r <= '0;
      end else if (state_r == ST_DONE && out_free && found_r) begin
        occ_r[best_r] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    req_r         <= req_nxt;
    best_r        <= best_nxt;
    best_size_r   <= best_size_nxt;
    out_granted_r <= out_granted_nxt;
    out_slot_r    <= out_slot_nxt;
    out_size_r    <= out_size_nxt;
  end

  // size table, written by load requests, read at the scan address
  always_ff @(posedge clk) begin
    if (in_take && in_func == FUNC_LOAD) begin
      size_mem[in_slot] <= in_amount;
    end
    rd_size_r <= size_mem[scan_slot];
  end

`include "best_fit_partition_allocator_assert.svh"

  `BFPA_ASSERT_RST(a_rst_out_idle, !rst_n |=> !out_valid_r, "result valid right after reset")
  `BFPA_ASSERT(a_scan_bound, (state_r == ST_SCAN) |-> (idx_r <= cnt_r), "scan index past count")
  `BFPA_ASSERT(a_nogrant_zero, (out_valid_r && !out_granted_r) |-> (out_slot_r == '0 && out_size_r == '0), "refused result not zero")
  `BFPA_ASSERT(a_grant_marks, (state_r == ST_DONE && out_free && found_r) |=> occ_r[best_r], "granted partition not marked")

endmodule

// ===== verif/tb.sv =====
`timescale 1ns / 100ps
// testbench for best_fit_partition_allocator: directed and random requests, checked
// against an in-bench best-fit predictor; needs bfpa_pkg.sv and the allocator rtl
module tb;
  import bfpa_pkg::*;

  localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;
  localparam int STALL_CYCLES = 300;

  typedef struct packed {
    logic [FUNC_W-1:0] func;
    slot_t             slot;
    size_t             amount;
  } alloc_req_t;

  typedef struct packed {
    logic  granted;
    slot_t slot;
    size_t size;
  } grant_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic              cfg_valid = 1'b0;
  logic              cfg_ready;
  logic [CFG_W-1:0]  cfg_data = '0;
  logic              in_valid = 1'b0;
  logic              in_ready;
  logic [FUNC_W-1:0] in_func = FUNC_LOAD;
  slot_t             in_slot = '0;
  size_t             in_amount = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic              out_granted;
  slot_t             out_chosen_slot;
  size_t             out_chosen_size;

  alloc_req_t req_backlog[$];
  grant_t     grant_expect[$];
  int         reqs_queued = 0;
  int         reqs_taken = 0;
  int         mismatch_cnt = 0;
  bit         calm = 1'b0;

  // shadow of the allocator state
  size_t                part_size_shadow[MAX_PARTS];
  logic [MAX_PARTS-1:0] part_busy_shadow = '0;
  int                   live_parts = 0;

  int tx_gap = 0;
  int rx_wait = 0;
  int stall_req = 0;
  int stall_seen = 0;
  int stall_left = 0;

  best_fit_partition_allocator i_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_data        (cfg_data),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_func         (in_func),
    .in_slot         (in_slot),
    .in_amount       (in_amount),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_granted     (out_granted),
    .out_chosen_slot (out_chosen_slot),
    .out_chosen_size (out_chosen_size)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic grant_t predict_grant(alloc_req_t r);
    grant_t g;
    int     lim;
    logic   hit;
    size_t  best_sz;
    slot_t  best_ix;
    g = '0;
    hit = 1'b0;
    best_sz = '0;
    best_ix = '0;
    case (r.func)
      FUNC_LOAD: begin
        part_size_shadow[r.slot] = r.amount;
        part_busy_shadow[r.slot] = 1'b0;
      end
      FUNC_CLEAR: part_busy_shadow = '0;
      FUNC_ALLOC: begin
        lim = (live_parts > MAX_PARTS) ? MAX_PARTS : live_parts;
        for (int j = 0; j < lim; j++) begin
          if (!part_busy_shadow[j] && part_size_shadow[j] >= r.amount &&
              (!hit || part_size_shadow[j] < best_sz)) begin
            hit = 1'b1;
            best_ix = slot_t'(j);
            best_sz = part_size_shadow[j];
          end
        end
        if (hit) begin
          part_busy_shadow[best_ix] = 1'b1;
          g.granted = 1'b1;
          g.slot = best_ix;
          g.size = best_sz;
        end
      end
      default: ;
    endcase
    return g;
  endfunction

  function automatic int draw_idle();
    return calm ? 0 : $urandom_range(0, 8);
  endfunction

  // request driver
  always @(posedge clk) begin
    alloc_req_t r;
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_func <= FUNC_LOAD;
      in_slot <= '0;
      in_amount <= '0;
      tx_gap <= 0;
    end else begin
      if (in_valid && in_ready) begin
        grant_expect.push_back(predict_grant('{in_func, in_slot, in_amount}));
        reqs_taken++;
      end
      if (in_valid && !in_ready) begin
        // hold the request until taken
      end else if (tx_gap != 0) begin
        tx_gap <= tx_gap - 1;
        in_valid <= 1'b0;
      end else if (req_backlog.size() != 0) begin
        r = req_backlog.pop_front();
        in_func <= r.func;
        in_slot <= r.slot;
        in_amount <= r.amount;
        in_valid <= 1'b1;
        tx_gap <= draw_idle();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // long receiver hold-off, so the block backs up into its input
  always @(posedge clk) begin
    if (!rst_n) begin
      stall_left <= 0;
    end else if (stall_req != stall_seen) begin
      stall_seen <= stall_req;
      stall_left <= STALL_CYCLES;
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
    end
  end

  // result receiver
  always @(posedge clk) begin
    int w;
    if (!rst_n) begin
      out_ready <= 1'b0;
      rx_wait <= 0;
    end else if (stall_left != 0) begin
      out_ready <= 1'b0;
    end else if (out_valid && out_ready) begin
      w = draw_idle();
      rx_wait <= w;
      out_ready <= (w == 0);
    end else if (rx_wait != 0) begin
      rx_wait <= rx_wait - 1;
      out_ready <= (rx_wait == 1);
    end else begin
      out_ready <= 1'b1;
    end
  end

  // result checker
  always @(posedge clk) begin
    grant_t e;
    if (rst_n && out_valid && out_ready) begin
      if (grant_expect.size() == 0) begin
        $error("result with no request pending: granted %0d slot %0d size %0d",
               out_granted, out_chosen_slot, out_chosen_size);
        mismatch_cnt++;
      end else begin
        e = grant_expect.pop_front();
        if (out_granted !== e.granted) begin
          $error("granted: expected %0d, got %0d", e.granted, out_granted);
          mismatch_cnt++;
        end
        if (out_chosen_slot !== e.slot) begin
          $error("chosen_slot: expected %0d, got %0d", e.slot, out_chosen_slot);
          mismatch_cnt++;
        end
        if (out_chosen_size !== e.size) begin
          $error("chosen_size: expected %0d, got %0d", e.size, out_chosen_size);
          mismatch_cnt++;
        end
      end
    end
  end

  function automatic void queue_req(logic [FUNC_W-1:0] f, slot_t s, size_t a);
    req_backlog.push_back('{f, s, a});
    reqs_queued++;
  endfunction

  function automatic void queue_random_req(bit narrow);
    int    pick;
    slot_t s;
    size_t a;
    pick = $urandom_range(0, 99);
    s = slot_t'($urandom_range(0, 15));
    a = size_t'($urandom);
    if (pick < 55) begin
      // requests skewed small so that most of them find a partition
      a = narrow ? size_t'($urandom_range(0, 40)) : a >> $urandom_range(0, 16);
      queue_req(FUNC_ALLOC, s, a);
    end else if (pick < 87) begin
      if (narrow)
        a = size_t'($urandom_range(0, 40));
      queue_req(FUNC_LOAD, s, a);
    end else if (pick < 95) begin
      queue_req(FUNC_CLEAR, s, a);
    end else begin
      queue_req(FUNC_UNUSED, s, a);
    end
  endfunction

  task automatic wait_idle();
    do @(posedge clk);
    while (reqs_taken != reqs_queued || grant_expect.size() != 0);
  endtask

  task automatic write_part_count(logic [CFG_W-1:0] v);
    cfg_valid <= 1'b1;
    cfg_data <= v;
    do @(posedge clk);
    while (!cfg_ready);
    live_parts = v;
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  initial begin
    int counts[9];
    counts = '{16, 1, 31, 0, 8, 17, 5, 16, 0};
    counts[8] = $urandom_range(0, 31);
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // no partitions in use yet, unused op code, clear
    queue_req(FUNC_ALLOC, 4'd0, 16'd0);
    queue_req(FUNC_UNUSED, 4'd15, 16'hFFFF);
    queue_req(FUNC_CLEAR, 4'd0, 16'd0);
    // fill the whole table; loads land outside the in-use range
    queue_req(FUNC_LOAD, 4'd0, 16'd100);
    queue_req(FUNC_LOAD, 4'd1, 16'hFFFF);
    queue_req(FUNC_LOAD, 4'd2, 16'd50);
    queue_req(FUNC_LOAD, 4'd3, 16'd50);
    queue_req(FUNC_LOAD, 4'd4, 16'd0);
    queue_req(FUNC_LOAD, 4'd5, 16'd200);
    queue_req(FUNC_LOAD, 4'd6, 16'hAAAA);
    queue_req(FUNC_LOAD, 4'd7, 16'h5555);
    queue_req(FUNC_LOAD, 4'd8, 16'd50);
    for (int i = 9; i < MAX_PARTS; i++)
      queue_req(FUNC_LOAD, slot_t'(i), size_t'(1000 + i));
    wait_idle();
    write_part_count(5'd0);
    write_part_count(5'd4);
    // ties go low, entry 8 is out of range
    queue_req(FUNC_ALLOC, 4'd0, 16'd50);
    queue_req(FUNC_ALLOC, 4'd0, 16'd50);
    queue_req(FUNC_ALLOC, 4'd0, 16'd50);
    queue_req(FUNC_ALLOC, 4'd0, 16'd1);
    wait_idle();
    // count above the table size
    write_part_count(5'd31);
    queue_req(FUNC_ALLOC, 4'd0, 16'd0);
    queue_req(FUNC_ALLOC, 4'd0, 16'hFFFF);
    queue_req(FUNC_CLEAR, 4'd0, 16'd0);
    queue_req(FUNC_ALLOC, 4'd0, 16'hFFFF);
    wait_idle();

    for (int p = 0; p < 9; p++) begin
      calm = (p % 3 == 2);
      write_part_count(counts[p][CFG_W-1:0]);
      if (p == 1)
        stall_req <= stall_req + 1;
      for (int k = 0; k < 135; k++)
        queue_random_req(p % 2 == 1);
      wait_idle();
    end

    repeat (40) @(posedge clk);
    if (mismatch_cnt == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    #5_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+sv
sv/bfpa_pkg.sv
sv/best_fit_partition_allocator.sv
verif/tb.sv
